// ===== hw/rtl/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants of the text mode console writer: cell codes,
// request function codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tmcw_pkg;

   // default grid size
   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 25;

   // width of a linear cell index for any row (5 bits) and column (7 bits)
   localparam int IDX_W = 12;

   localparam logic [7:0]  BLANK_CHAR     = 8'h20;
   localparam logic [7:0]  NEWLINE_CHAR   = 8'h0A;
   localparam logic [7:0]  BACKSPACE_CHAR = 8'h08;
   localparam logic [7:0]  RESET_COLOUR   = 8'h07;
   localparam logic [15:0] RESET_CELL     = 16'h0720;

   // request function codes
   localparam logic [1:0] FUNC_PUT_CHAR = 2'd0;
   localparam logic [1:0] FUNC_CLEAR    = 2'd1;
   localparam logic [1:0] FUNC_PUT_AT   = 2'd2;
   localparam logic [1:0] FUNC_READ     = 2'd3;

   typedef struct packed {
      logic accept;       // latch the request payload
      logic exec;         // cursor update and single cell access
      logic copy_rd;      // scroll: read the cell one row below the pointer
      logic copy_wr;      // scroll: write the read cell at the pointer
      logic fill_blank;   // write a blank in text colour at the pointer
      logic fill_reset;   // write the reset cell at the pointer
      logic capture_read; // load the read result
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       need_scroll;
      logic       copy_last;
      logic       fill_last;
   } status_type;

endpackage

// ===== hw/rtl/text_mode_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Character cell console with cursor, scroll and clear.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass writes all ROWS*COLS
// cells with req_tready low. Put-char and put-at pass through the accept,
// execute and result states back to ready; read adds a wait state because
// of the registered memory read. A put-char that scrolls copies the rows up
// cell by cell, a read and a write per cell, through the single memory port
// pair, then blanks the bottom row; clear blanks all ROWS*COLS cells.
// csr_wr_data sets the text colour; it is to be written only when no request
// is in flight, which the block itself does not enforce.
module text_mode_console_writer
   import tmcw_pkg::*;
#(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[7:0], row[12:8], col[19:13], cell_colour[27:20], zero[31:28]
   input  logic [31:0] req_tdata,
   // func[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_word[15:0], cursor_pos[26:16], zero[31:27]
   output logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   cmd_type     cmd;
   status_type  status;
   logic [15:0] cell_word;
   logic [10:0] cursor_pos;

   tmcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tmcw_dp #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_tuser),
      .req_char_code   (req_tdata[7:0]),
      .req_row         (req_tdata[12:8]),
      .req_col         (req_tdata[19:13]),
      .req_cell_colour (req_tdata[27:20]),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_cell_word   (cell_word),
      .rsp_cursor_pos  (cursor_pos)
   );

   assign rsp_tdata = {5'd0, cursor_pos, cell_word};

endmodule

// ===== hw/rtl/tmcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Sequencer of the console writer: reset clearing pass, request handshake,
// scroll copy and fill sweeps, and the result handshake.
// ----------------------------------------------------------------------------
module tmcw_ctrl
   import tmcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_FILL_RST = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_EXEC     = 8'b0000_0100,
      ST_RD_WAIT  = 8'b0000_1000,
      ST_SCR_RD   = 8'b0001_0000,
      ST_SCR_WR   = 8'b0010_0000,
      ST_FILL     = 8'b0100_0000,
      ST_RESP     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL_RST;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_FILL_RST: begin
            cmd.fill_reset = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (status.func)
               FUNC_PUT_CHAR: state_in = status.need_scroll ? ST_SCR_RD : ST_RESP;
               FUNC_CLEAR:    state_in = ST_FILL;
               FUNC_PUT_AT:   state_in = ST_RESP;
               default:       state_in = ST_RD_WAIT;
            endcase
         end
         ST_RD_WAIT: begin
            cmd.capture_read = 1'b1;
            state_in         = ST_RESP;
         end
         ST_SCR_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            cmd.copy_wr = 1'b1;
            // the pointer runs on into the bottom row for blanking
            state_in    = status.copy_last ? ST_FILL : ST_SCR_RD;
         end
         ST_FILL: begin
            cmd.fill_blank = 1'b1;
            if (status.fill_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_FILL_RST;
         end
      endcase
   end

endmodule

// ===== hw/rtl/tmcw_dp.sv =====
// ----------------------------------------------------------------------------
// tmcw_dp
// Datapath of the console writer: cell memory, cursor, text colour,
// sweep pointer and result register.
// ----------------------------------------------------------------------------
module tmcw_dp
   import tmcw_pkg::*;
#(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_row,
   input  logic [6:0]  req_col,
   input  logic [7:0]  req_cell_colour,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [15:0] rsp_cell_word,
   output logic [10:0] rsp_cursor_pos
);

   localparam int NCELLS = ROWS * COLS;
   localparam int COPY_N = (ROWS - 1) * COLS;
   localparam int ADDR_W = $clog2(NCELLS);

   logic [15:0] mem_q [NCELLS];

   // request payload
   logic [1:0]  func_ff;
   logic [7:0]  char_ff;
   logic [4:0]  row_ff;
   logic [6:0]  col_ff;
   logic [7:0]  attr_ff;

   logic [7:0]        colour_ff;
   logic [4:0]        cursor_row_ff, cursor_row_in;
   logic [6:0]        cursor_col_ff, cursor_col_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [15:0]       word_ff, word_in;
   logic [15:0]       rd_data_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]       wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   logic [IDX_W-1:0] cur_full;
   logic [IDX_W-1:0] req_full;
   logic [IDX_W-1:0] bs_full;
   logic             in_range;
   logic             is_nl;
   logic             is_bs;
   logic             at_last_row;
   logic             at_last_col;
   logic [15:0]      blank_cell;

   assign cur_full = IDX_W'(cursor_row_ff) * IDX_W'(COLS) + IDX_W'(cursor_col_ff);
   assign req_full = IDX_W'(row_ff) * IDX_W'(COLS) + IDX_W'(col_ff);
   assign bs_full  = cur_full - IDX_W'(1);
   assign in_range = ({1'b0, row_ff} < 6'(ROWS)) && ({1'b0, col_ff} < 8'(COLS));

   assign is_nl       = (char_ff == NEWLINE_CHAR);
   assign is_bs       = (char_ff == BACKSPACE_CHAR);
   assign at_last_row = (cursor_row_ff == 5'(ROWS - 1));
   assign at_last_col = (cursor_col_ff == 7'(COLS - 1));
   assign blank_cell  = {colour_ff, BLANK_CHAR};

   assign status.func        = func_ff;
   assign status.need_scroll = (func_ff == FUNC_PUT_CHAR) && at_last_row &&
                               (is_nl || (!is_bs && at_last_col));
   assign status.copy_last   = (ptr_ff == ADDR_W'(COPY_N - 1));
   assign status.fill_last   = (ptr_ff == ADDR_W'(NCELLS - 1));

   assign rsp_cell_word  = word_ff;
   assign rsp_cursor_pos = cur_full[10:0];

   always_comb begin
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      ptr_in        = ptr_ff;
      word_in       = word_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = RESET_CELL;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff + ADDR_W'(COLS);

      if (cmd.fill_reset) begin
         wr_en  = 1'b1;
         ptr_in = ptr_ff + ADDR_W'(1);
      end else if (cmd.fill_blank) begin
         wr_en   = 1'b1;
         wr_data = blank_cell;
         ptr_in  = ptr_ff + ADDR_W'(1);
      end else if (cmd.copy_rd) begin
         rd_en = 1'b1;
      end else if (cmd.copy_wr) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff;
         ptr_in  = ptr_ff + ADDR_W'(1);
      end else if (cmd.capture_read) begin
         word_in = in_range ? rd_data_ff : 16'h0000;
      end else if (cmd.exec) begin
         ptr_in  = '0;
         word_in = 16'h0000;
         case (func_ff)
            FUNC_PUT_CHAR: begin
               if (is_nl) begin
                  cursor_col_in = '0;
                  if (!at_last_row) begin
                     cursor_row_in = cursor_row_ff + 5'd1;
                  end
               end else if (is_bs) begin
                  if (cursor_col_ff != 7'd0) begin
                     cursor_col_in = cursor_col_ff - 7'd1;
                     wr_en         = 1'b1;
                     wr_addr       = bs_full[ADDR_W-1:0];
                     wr_data       = blank_cell;
                  end
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = cur_full[ADDR_W-1:0];
                  wr_data = {colour_ff, char_ff};
                  if (at_last_col) begin
                     cursor_col_in = '0;
                     // on the last row the scroll keeps the cursor there
                     if (!at_last_row) begin
                        cursor_row_in = cursor_row_ff + 5'd1;
                     end
                  end else begin
                     cursor_col_in = cursor_col_ff + 7'd1;
                  end
               end
            end
            FUNC_CLEAR: begin
               cursor_row_in = '0;
               cursor_col_in = '0;
            end
            FUNC_PUT_AT: begin
               wr_en   = in_range;
               wr_addr = req_full[ADDR_W-1:0];
               wr_data = {attr_ff, char_ff};
            end
            default: begin
               rd_en   = in_range;
               rd_addr = req_full[ADDR_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff     <= RESET_COLOUR;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         ptr_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            colour_ff <= csr_wr_data;
         end
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         ptr_ff        <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (cmd.accept) begin
         func_ff <= req_func;
         char_ff <= req_char_code;
         row_ff  <= req_row;
         col_ff  <= req_col;
         attr_ff <= req_cell_colour;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text mode console writer.
// ----------------------------------------------------------------------------
// A step queue of console requests, drain pauses and colour writes is built
// up front and fed to a stream driver. A shadow console (cell grid, cursor,
// text colour) works out each response when its request is accepted. The
// monitor checks cell word and cursor position in order. Both stream sides
// stall in random bursts, except near the end of the run.
module tb;
   import tmcw_pkg::*;

   localparam int COLS          = DEF_COLS;
   localparam int ROWS          = DEF_ROWS;
   localparam int CELLS         = COLS * ROWS;
   localparam int RANDOM_ITEMS  = 550;
   localparam int PHASES        = 6;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_TAIL    = 60;

   typedef enum logic [1:0] {STEP_REQ, STEP_DRAIN, STEP_CSR} step_kind_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] char_code;
      logic [4:0] row;
      logic [6:0] col;
      logic [7:0] cell_colour;
   } console_req_type;

   typedef struct packed {
      logic [15:0] cell_word;
      logic [10:0] cursor_pos;
   } console_rsp_type;

   typedef struct packed {
      step_kind_type   kind;
      console_req_type req;
      logic [7:0]      colour;
   } step_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   // shadow console
   logic [15:0] shadow_cells [CELLS];
   logic [4:0]  shadow_row;
   logic [6:0]  shadow_col;
   logic [7:0]  shadow_colour;

   step_type        step_q [$];
   console_rsp_type due_rsp_q [$];
   console_req_type drive_req;

   int req_total      = 0;
   int sent_count     = 0;
   int rsp_count      = 0;
   int quiet_from     = 0;
   int gap_left       = 0;
   int settle_left    = 0;
   int stall_left     = 0;
   int send_idle_pct  = 20;
   int recv_stall_pct = 20;
   int error_count    = 0;
   int scroll_count   = 0;
   int colour_writes  = 0;
   int cycle_count    = 0;
   int cycle_limit    = 0;
   int func_count [4] = '{0, 0, 0, 0};

   text_mode_console_writer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // applies one request to the shadow console and returns its response
   function automatic console_rsp_type console_step(console_req_type rq);
      console_rsp_type rs;
      logic            hit;
      int              at;
      int              cur;
      rs  = '0;
      hit = (rq.row < ROWS) && (rq.col < COLS);
      at  = int'(rq.row) * COLS + int'(rq.col);
      cur = int'(shadow_row) * COLS + int'(shadow_col);
      case (rq.func)
         FUNC_PUT_CHAR: begin
            if (rq.char_code == NEWLINE_CHAR) begin
               shadow_col = '0;
               shadow_row = shadow_row + 5'd1;
            end else if (rq.char_code == BACKSPACE_CHAR) begin
               if (shadow_col != 0) begin
                  shadow_col = shadow_col - 7'd1;
                  shadow_cells[cur - 1] = {shadow_colour, BLANK_CHAR};
               end
            end else begin
               shadow_cells[cur] = {shadow_colour, rq.char_code};
               shadow_col = shadow_col + 7'd1;
               if (shadow_col >= COLS) begin
                  shadow_col = '0;
                  shadow_row = shadow_row + 5'd1;
               end
            end
            // ran off the bottom: move everything up one row
            if (shadow_row >= ROWS) begin
               for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
               for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = {shadow_colour, BLANK_CHAR};
               shadow_row = 5'(ROWS - 1);
               scroll_count++;
            end
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_colour, BLANK_CHAR};
            shadow_row = '0;
            shadow_col = '0;
         end
         FUNC_PUT_AT: begin
            if (hit) shadow_cells[at] = {rq.cell_colour, rq.char_code};
         end
         default: begin
            if (hit) rs.cell_word = shadow_cells[at];
         end
      endcase
      rs.cursor_pos = 11'(int'(shadow_row) * COLS + int'(shadow_col));
      return rs;
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 15;
         2:       return 40;
         default: return 70;
      endcase
   endfunction

   task automatic push_req(logic [1:0] func, int unsigned ch, int unsigned row,
                           int unsigned col, int unsigned attr);
      step_type s;
      s.kind            = STEP_REQ;
      s.req.func        = func;
      s.req.char_code   = 8'(ch);
      s.req.row         = 5'(row);
      s.req.col         = 7'(col);
      s.req.cell_colour = 8'(attr);
      s.colour          = '0;
      step_q.push_back(s);
      req_total++;
   endtask

   task automatic push_drain();
      step_type s;
      s        = '0;
      s.kind   = STEP_DRAIN;
      step_q.push_back(s);
   endtask

   task automatic push_colour(logic [7:0] colour);
      step_type s;
      s        = '0;
      s.kind   = STEP_CSR;
      s.colour = colour;
      push_drain();
      step_q.push_back(s);
   endtask

   // put-at or read, mostly on the grid and often near the bottom rows
   task automatic push_cell_op(logic [1:0] func);
      int unsigned row;
      int unsigned col;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            row = $urandom_range(0, 31);
            col = $urandom_range(0, 127);
         end
         3, 4, 5: begin
            row = $urandom_range(ROWS - 7, ROWS - 1);
            col = $urandom_range(0, COLS - 1);
         end
         default: begin
            row = $urandom_range(0, ROWS - 1);
            col = $urandom_range(0, COLS - 1);
         end
      endcase
      push_req(func, $urandom(), row, col, $urandom());
   endtask

   task automatic add_text(int len);
      logic [7:0] ch;
      for (int i = 0; i < len; i++) begin
         ch = 8'($urandom());
         if (ch == NEWLINE_CHAR) ch = ch ^ 8'h40;
         push_req(FUNC_PUT_CHAR, ch, $urandom(), $urandom(), $urandom());
      end
   endtask

   task automatic add_newlines(int count);
      for (int i = 0; i < count; i++)
         push_req(FUNC_PUT_CHAR, NEWLINE_CHAR, $urandom(), $urandom(), $urandom());
   endtask

   task automatic add_random_sequence();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         add_text(($urandom_range(0, 5) == 0) ? $urandom_range(70, 90) : $urandom_range(1, 20));
         if ($urandom_range(0, 1) == 0) add_newlines(1);
      end else if (pick < 52) begin
         add_newlines(($urandom_range(0, 4) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8));
      end else if (pick < 62) begin
         for (int i = $urandom_range(1, 5); i > 0; i--)
            push_req(FUNC_PUT_CHAR, BACKSPACE_CHAR, $urandom(), $urandom(), $urandom());
      end else if (pick < 76) begin
         push_cell_op(FUNC_PUT_AT);
      end else if (pick < 96) begin
         push_cell_op(FUNC_READ);
      end else begin
         push_req(FUNC_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
      end
   endtask

   // request driver
   always @(posedge clock) begin : driver
      logic     valid_next;
      logic     wr_next;
      step_type head;
      valid_next = req_tvalid;
      wr_next    = 1'b0;
      if (reset) begin
         valid_next = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_rsp_q.push_back(console_step(drive_req));
            func_count[drive_req.func]++;
            sent_count++;
            valid_next = 1'b0;
            if (sent_count % 32 == 0) send_idle_pct = pick_idle_pct();
         end
         if (!valid_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (step_q.size() > 0) begin
               head = step_q[0];
               case (head.kind)
                  STEP_REQ: begin
                     if (sent_count < quiet_from && $urandom_range(0, 99) < send_idle_pct) begin
                        gap_left = $urandom_range(1, 9) - 1;
                     end else begin
                        void'(step_q.pop_front());
                        drive_req  = head.req;
                        valid_next = 1'b1;
                        req_tdata <= {4'b0, head.req.cell_colour, head.req.col,
                                      head.req.row, head.req.char_code};
                        req_tuser <= head.req.func;
                     end
                  end
                  STEP_DRAIN: begin
                     // hold off until every response is in, then let the block settle
                     if (due_rsp_q.size() == 0) begin
                        if (settle_left < SETTLE_CYCLES) begin
                           settle_left++;
                        end else begin
                           settle_left = 0;
                           void'(step_q.pop_front());
                        end
                     end
                  end
                  default: begin
                     void'(step_q.pop_front());
                     wr_next       = 1'b1;
                     csr_wr_data  <= head.colour;
                     shadow_colour = head.colour;
                     colour_writes++;
                  end
               endcase
            end
         end
      end
      req_tvalid <= valid_next;
      csr_wr_en  <= wr_next;
   end

   // response monitor
   always @(posedge clock) begin : monitor
      logic            ready_next;
      console_rsp_type got;
      console_rsp_type want;
      ready_next = rsp_tready;
      if (reset) begin
         ready_next = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cell_word  = rsp_tdata[15:0];
            got.cursor_pos = rsp_tdata[26:16];
            rsp_count++;
            if (rsp_count % 32 == 0) recv_stall_pct = pick_idle_pct();
            if (due_rsp_q.size() == 0) begin
               $display("%0t: response with none outstanding, got %h", $time, got);
               error_count++;
            end else begin
               want = due_rsp_q.pop_front();
               if (got.cell_word !== want.cell_word) begin
                  $display("%0t: cell_word mismatch, expected %h, got %h",
                           $time, want.cell_word, got.cell_word);
                  error_count++;
               end
               if (got.cursor_pos !== want.cursor_pos) begin
                  $display("%0t: cursor_pos mismatch, expected %0d, got %0d",
                           $time, want.cursor_pos, got.cursor_pos);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (sent_count < quiet_from && $urandom_range(0, 99) < recv_stall_pct) begin
            stall_left = $urandom_range(1, 9) - 1;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
      end
      rsp_tready <= ready_next;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("%0t: timeout with %0d requests unsent, %0d responses awaited",
                  $time, step_q.size(), due_rsp_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0] phase_colour [PHASES];
      int         target;
      int         directed_count;

      for (int i = 0; i < CELLS; i++) shadow_cells[i] = RESET_CELL;
      shadow_row    = '0;
      shadow_col    = '0;
      shadow_colour = RESET_COLOUR;

      // directed: reset contents, cursor specials, range edges, clear
      push_req(FUNC_READ, 0, 0, 0, 0);
      push_req(FUNC_READ, 0, ROWS - 1, COLS - 1, 0);
      push_req(FUNC_PUT_CHAR, BACKSPACE_CHAR, 0, 0, 0);
      push_req(FUNC_PUT_CHAR, 8'h00, 31, 127, 255);
      push_req(FUNC_PUT_CHAR, 8'hFF, 0, 0, 0);
      push_req(FUNC_PUT_CHAR, 8'h41, 0, 0, 0);
      push_req(FUNC_PUT_CHAR, BACKSPACE_CHAR, 0, 0, 0);
      push_req(FUNC_PUT_CHAR, NEWLINE_CHAR, 0, 0, 0);
      push_req(FUNC_PUT_AT, 8'h41, 0, COLS - 1, 8'hFF);
      push_req(FUNC_PUT_AT, 8'hFF, ROWS - 1, 0, 8'h00);
      push_req(FUNC_PUT_AT, 8'h5A, ROWS, 0, 8'h1E);
      push_req(FUNC_PUT_AT, 8'h5A, 31, 127, 8'h1E);
      push_req(FUNC_PUT_AT, 8'h5A, 0, COLS, 8'h1E);
      push_req(FUNC_READ, 0, 0, COLS - 1, 0);
      push_req(FUNC_READ, 0, ROWS - 1, 0, 0);
      push_req(FUNC_READ, 255, 31, 127, 255);
      push_req(FUNC_READ, 0, ROWS, 0, 0);
      push_req(FUNC_READ, 0, 0, COLS, 0);
      push_req(FUNC_READ, 0, 0, 2, 0);
      push_req(FUNC_CLEAR, 255, 31, 127, 255);
      push_req(FUNC_READ, 0, 12, 40, 0);
      push_req(FUNC_READ, 0, 0, COLS - 1, 0);
      push_req(FUNC_PUT_CHAR, NEWLINE_CHAR, 0, 0, 0);
      directed_count = req_total;

      phase_colour = '{8'h00, 8'hFF, 8'h1F, 8'($urandom()), 8'($urandom()), 8'hF0};
      for (int p = 0; p < PHASES; p++) begin
         push_colour(phase_colour[p]);
         // first phase runs off the bottom and wraps a full line early on
         if (p == 0) begin
            add_newlines(ROWS + 1);
            add_text(COLS + 5);
         end
         target = directed_count + (p + 1) * RANDOM_ITEMS / PHASES;
         while (req_total < target) begin
            add_random_sequence();
            if ($urandom_range(0, 29) == 0) push_drain();
         end
      end

      quiet_from  = req_total - QUIET_TAIL;
      cycle_limit = 4 * (2 * CELLS + req_total * (2 * (ROWS - 1) * COLS + COLS + 40)
                         + step_q.size() * (SETTLE_CYCLES + 10));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (step_q.size() != 0 || req_tvalid || due_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d put-char, %0d clear, %0d put-at, %0d read",
               sent_count, func_count[FUNC_PUT_CHAR], func_count[FUNC_CLEAR],
               func_count[FUNC_PUT_AT], func_count[FUNC_READ]);
      $display("%0d scrolls, %0d text colour writes, %0d mismatches",
               scroll_count, colour_writes, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
